// ===== src/krt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_pkg
// Shared sizes, request codes and helpers of the keyed record table.
// ----------------------------------------------------------------------------
package krt_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int NAME_BYTES  = 8;

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int KEY_W  = 32;
   localparam int NAME_W = 64;
   localparam int SLOT_W = 8;
   localparam int ECNT_W = 9;
   localparam int REQ_W  = 2;

   localparam logic [NAME_W-1:0] NAME_MASK = {NAME_W{1'b1}} >> (NAME_W - 8 * NAME_BYTES);

   typedef enum logic [REQ_W-1:0] {
      OP_INSERT = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_DELETE = 2'd2
   } op_type;

   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

endpackage

// ===== src/keyed_record_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_record_table
// Fixed-capacity record table with valid bits: insert into the lowest free
// slot, look up by key, delete by name, one slot examined per cycle.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  request   start && !busy       req_type, req_student_id, req_student_name
//  response  rsp_valid (1 cycle)  rsp_found, rsp_slot_index, rsp_result_id,
//                                 rsp_result_name, rsp_entry_count
//
// A request scans from slot 0 upward and stops at the first hit or at
// the last slot; busy stays high for the whole scan, so no new word is
// accepted until it ends. Each slot goes through the registered store read
// to the single compare unit. An unused request code is answered with no scan.
// Reset clears all valid bits and the count at once; no clearing pass.
// The receiver cannot stall the response.
module keyed_record_table
   import krt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [REQ_W-1:0]         req_type,
   input  logic signed [KEY_W-1:0]  req_student_id,
   input  logic [NAME_W-1:0]        req_student_name,
   output logic                     rsp_valid,
   output logic                     rsp_found,
   output logic [SLOT_W-1:0]        rsp_slot_index,
   output logic signed [KEY_W-1:0]  rsp_result_id,
   output logic [NAME_W-1:0]        rsp_result_name,
   output logic [ECNT_W-1:0]        rsp_entry_count
);

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [NAME_W-1:0] name_ff, name_in;
   logic [IDX_W-1:0]  addr_ff, addr_in;
   logic [IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [KEY_W-1:0]  rsp_id_ff, rsp_id_in;
   logic [NAME_W-1:0] rsp_name_ff, rsp_name_in;
   logic [ECNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [KEY_W-1:0]  rd_key;
   logic [NAME_W-1:0] rd_name;
   logic              cur_valid;
   logic              hit;
   logic              last;
   logic              accept;
   logic              wr_en;

   assign accept    = start && (state_ff == ST_IDLE);
   assign cur_valid = valid_ff[cmp_idx_ff];
   assign last      = (cmp_idx_ff == IDX_W'(TABLE_DEPTH - 1));
   assign wr_en     = (state_ff == ST_SCAN) && cmp_vld_ff && hit && (op_ff == OP_INSERT);

   always_comb begin
      unique case (op_ff)
         OP_INSERT: hit = !cur_valid;
         OP_LOOKUP: hit = cur_valid && (rd_key == key_ff);
         OP_DELETE: hit = cur_valid && (rd_name == name_ff);
         default:   hit = 1'b0;
      endcase
   end

   krt_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cmp_idx_ff),
      .wr_data (key_ff),
      .rd_en   (state_ff == ST_SCAN),
      .rd_addr (addr_ff),
      .rd_data (rd_key)
   );

   krt_ram #(.WIDTH(NAME_W), .DEPTH(TABLE_DEPTH)) u_name_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cmp_idx_ff),
      .wr_data (name_ff),
      .rd_en   (state_ff == ST_SCAN),
      .rd_addr (addr_ff),
      .rd_data (rd_name)
   );

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      name_in      = name_ff;
      addr_in      = addr_ff;
      cmp_idx_in   = cmp_idx_ff;
      cmp_vld_in   = cmp_vld_ff;
      valid_in     = valid_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_found_in = rsp_found_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_name_in  = rsp_name_ff;
      rsp_count_in = rsp_count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_in     = $unsigned(req_student_id);
               name_in    = req_student_name & NAME_MASK;
               addr_in    = '0;
               cmp_vld_in = 1'b0;
               if (req_type == REQ_UNUSED) begin
                  rsp_valid_in = 1'b1;
                  rsp_found_in = 1'b0;
                  rsp_slot_in  = '0;
                  rsp_id_in    = '0;
                  rsp_name_in  = '0;
                  rsp_count_in = ECNT_W'(count_ff);
               end else begin
                  op_in    = op_type'(req_type);
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            addr_in    = addr_ff + 1'b1;
            cmp_idx_in = addr_ff;
            cmp_vld_in = 1'b1;
            if (cmp_vld_ff && (hit || last)) begin
               state_in     = ST_IDLE;
               cmp_vld_in   = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_found_in = hit;
               rsp_slot_in  = hit ? SLOT_W'(cmp_idx_ff) : '0;
               rsp_id_in    = (hit && (op_ff == OP_LOOKUP)) ? rd_key : '0;
               rsp_name_in  = (hit && (op_ff == OP_LOOKUP)) ? rd_name : '0;
               if (hit && (op_ff == OP_INSERT)) begin
                  valid_in[cmp_idx_ff] = 1'b1;
                  count_in = count_ff + 1'b1;
               end else if (hit && (op_ff == OP_DELETE)) begin
                  valid_in[cmp_idx_ff] = 1'b0;
                  count_in = count_ff - 1'b1;
               end
               rsp_count_in = ECNT_W'(count_in);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_vld_ff   <= 1'b0;
         valid_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_vld_ff   <= cmp_vld_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_ff       <= key_in;
      name_ff      <= name_in;
      addr_ff      <= addr_in;
      cmp_idx_ff   <= cmp_idx_in;
      rsp_found_ff <= rsp_found_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_name_ff  <= rsp_name_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_slot_index  = rsp_slot_ff;
   assign rsp_result_id   = $signed(rsp_id_ff);
   assign rsp_result_name = rsp_name_ff;
   assign rsp_entry_count = rsp_count_ff;

`ifndef SYNTHESIS
   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == 32'(count_ff))
      else $error("occupancy count differs from the number of valid slots");

   a_accept_leads_on: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted word neither started a scan nor answered");

   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_slot_index == '0 && rsp_result_id == '0
         && rsp_result_name == '0))
      else $error("unsuccessful response carries nonzero fields");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_entry_count) <= TABLE_DEPTH))
      else $error("reported occupancy exceeds the table size");
`endif

endmodule

// ===== src/krt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module krt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the keyed record table. Request words go in
// through the start/busy handshake. A behavioral copy of the table predicts
// each response word when its request is accepted. The response port then
// checks each rsp_valid word against the oldest prediction. The stimulus
// runs the empty table, extreme keys and names, duplicates, slot reuse and
// the unused code. Random traffic then mixes the operations, fills the table
// past capacity and deletes from it, with random gaps between request words.
// ----------------------------------------------------------------------------
module tb
   import krt_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = TABLE_DEPTH + 8;

   typedef struct packed {
      logic                    found;
      logic [SLOT_W-1:0]       slot;
      logic signed [KEY_W-1:0] id;
      logic [NAME_W-1:0]       name;
      logic [ECNT_W-1:0]       count;
   } table_reply_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [REQ_W-1:0]        req_type;
   logic signed [KEY_W-1:0] req_student_id;
   logic [NAME_W-1:0]       req_student_name;
   logic                    rsp_valid;
   logic                    rsp_found;
   logic [SLOT_W-1:0]       rsp_slot_index;
   logic signed [KEY_W-1:0] rsp_result_id;
   logic [NAME_W-1:0]       rsp_result_name;
   logic [ECNT_W-1:0]       rsp_entry_count;

   bit                      slot_live [TABLE_DEPTH];
   logic signed [KEY_W-1:0] slot_id [TABLE_DEPTH];
   logic [NAME_W-1:0]       slot_name [TABLE_DEPTH];
   int                      live_count;
   int                      high_water;

   table_reply_type pending_replies[$];
   int              error_count;
   int              quiet_cycles;
   bit              steady_stream;

   keyed_record_table dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_student_id   (req_student_id),
      .req_student_name (req_student_name),
      .rsp_valid        (rsp_valid),
      .rsp_found        (rsp_found),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_result_id    (rsp_result_id),
      .rsp_result_name  (rsp_result_name),
      .rsp_entry_count  (rsp_entry_count)
   );

   always #5 clock = ~clock;

   function automatic table_reply_type apply_request(logic [REQ_W-1:0] code,
                                                     logic signed [KEY_W-1:0] id,
                                                     logic [NAME_W-1:0] name);
      table_reply_type   r;
      logic [NAME_W-1:0] masked;
      r = '0;
      masked = name & NAME_MASK;
      case (code)
         OP_INSERT: begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (!slot_live[i]) begin
                  slot_live[i] = 1'b1;
                  slot_id[i]   = id;
                  slot_name[i] = masked;
                  live_count++;
                  if (i + 1 > high_water) high_water = i + 1;
                  r.found = 1'b1;
                  r.slot  = SLOT_W'(i);
                  break;
               end
            end
         end
         OP_LOOKUP: begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (slot_live[i] && slot_id[i] == id) begin
                  r.found = 1'b1;
                  r.slot  = SLOT_W'(i);
                  r.id    = slot_id[i];
                  r.name  = slot_name[i];
                  break;
               end
            end
         end
         OP_DELETE: begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (slot_live[i] && slot_name[i] == masked) begin
                  slot_live[i] = 1'b0;
                  if (live_count > 0) live_count--;
                  r.found = 1'b1;
                  r.slot  = SLOT_W'(i);
                  break;
               end
            end
         end
         default: ;
      endcase
      r.count = ECNT_W'(live_count);
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      if ($urandom_range(0, 24) == 0) steady_stream = !steady_stream;
      if (steady_stream) return 0;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 82) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Called at a rising edge; returns at the edge that accepts the word.
   task automatic send_word(logic [REQ_W-1:0] code, logic signed [KEY_W-1:0] id,
                            logic [NAME_W-1:0] name);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_type         <= code;
      req_student_id   <= id;
      req_student_name <= name;
      do @(posedge clock); while (busy);
      pending_replies.push_back(apply_request(code, id, name));
   endtask

   function automatic int live_slot_near(int origin);
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         if (slot_live[(origin + k) % TABLE_DEPTH]) return (origin + k) % TABLE_DEPTH;
      end
      return -1;
   endfunction

   function automatic logic signed [KEY_W-1:0] fresh_id();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return $urandom_range(0, 15);
      if (r < 40) begin
         case ($urandom_range(0, 3))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return -32'sd1;
            default: return 32'sd0;
         endcase
      end
      return $urandom;
   endfunction

   function automatic logic [NAME_W-1:0] fresh_name();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return 64'h4100 + $urandom_range(0, 15);
      if (r < 38) return $urandom_range(0, 1) ? '1 : '0;
      return {$urandom, $urandom};
   endfunction

   function automatic logic signed [KEY_W-1:0] probe_id();
      int r;
      int s;
      r = $urandom_range(0, 99);
      s = live_slot_near($urandom_range(0, TABLE_DEPTH - 1));
      if (r < 55 && s >= 0) return slot_id[s];
      if (r < 70 && high_water > 0) return slot_id[$urandom_range(0, high_water - 1)];
      return fresh_id();
   endfunction

   function automatic logic [NAME_W-1:0] probe_name();
      int r;
      int s;
      r = $urandom_range(0, 99);
      s = live_slot_near($urandom_range(0, TABLE_DEPTH - 1));
      if (r < 55 && s >= 0) return slot_name[s];
      if (r < 70 && high_water > 0) return slot_name[$urandom_range(0, high_water - 1)];
      return fresh_name();
   endfunction

   task automatic send_random_word(int insert_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < 3)
         send_word(REQ_UNUSED, $urandom, {$urandom, $urandom});
      else if (r < 3 + insert_pct)
         send_word(OP_INSERT, fresh_id(), fresh_name());
      else if (r % 2 == 0)
         send_word(OP_LOOKUP, probe_id(), {$urandom, $urandom});
      else
         send_word(OP_DELETE, $urandom, probe_name());
   endtask

   task automatic test_empty_table();
      send_word(OP_LOOKUP, 32'sd0, '0);
      send_word(OP_DELETE, 32'sd0, '0);
      send_word(REQ_UNUSED, 32'sd0, '0);
   endtask

   task automatic test_extremes_and_duplicates();
      send_word(OP_INSERT, 32'sh8000_0000, '0);
      send_word(OP_INSERT, 32'sh7fff_ffff, '1);
      send_word(OP_INSERT, 32'sd0, 64'h41);
      send_word(OP_INSERT, 32'sd7, '1);
      send_word(OP_INSERT, 32'sd7, 64'h42);
      send_word(OP_LOOKUP, 32'sh8000_0000, '0);
      send_word(OP_LOOKUP, 32'sh7fff_ffff, '1);
      send_word(OP_LOOKUP, 32'sd7, '0);
      send_word(OP_LOOKUP, 32'sd12345, '0);
      send_word(OP_DELETE, '1, '1);
      send_word(OP_LOOKUP, 32'sh7fff_ffff, '0);
      send_word(OP_DELETE, 32'sd0, '1);
      send_word(OP_LOOKUP, 32'sd7, '0);
   endtask

   task automatic test_reuse_and_unused_code();
      send_word(OP_INSERT, -32'sd1, 64'h0102_0304_0506_0708);
      send_word(OP_DELETE, 32'sd0, 64'h43);
      send_word(REQ_UNUSED, 32'sh5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
      send_word(OP_DELETE, 32'sd0, '0);
      send_word(OP_INSERT, 32'sh5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
      send_word(OP_LOOKUP, 32'sd0, '0);
      send_word(OP_LOOKUP, -32'sd1, '0);
   endtask

   task automatic test_random_mix(int words, int insert_pct);
      repeat (words) send_random_word(insert_pct);
   endtask

   task automatic test_fill_to_capacity();
      while (live_count < TABLE_DEPTH) send_random_word(85);
      repeat (4) send_word(OP_INSERT, fresh_id(), fresh_name());
      send_word(OP_LOOKUP, probe_id(), '0);
      send_word(OP_DELETE, 32'sd0, probe_name());
      send_word(OP_INSERT, fresh_id(), fresh_name());
      send_word(OP_INSERT, fresh_id(), fresh_name());
   endtask

   always @(posedge clock) begin
      table_reply_type want;
      if (!reset && rsp_valid) begin
         if (pending_replies.size() == 0) begin
            $error("unexpected response word: found %0d slot %0d",
                   rsp_found, rsp_slot_index);
            error_count++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_found !== want.found) begin
               $error("rsp_found: expected %0d, got %0d", want.found, rsp_found);
               error_count++;
            end
            if (rsp_slot_index !== want.slot) begin
               $error("rsp_slot_index: expected %0d, got %0d", want.slot, rsp_slot_index);
               error_count++;
            end
            if (rsp_result_id !== want.id) begin
               $error("rsp_result_id: expected %0d, got %0d", want.id, rsp_result_id);
               error_count++;
            end
            if (rsp_result_name !== want.name) begin
               $error("rsp_result_name: expected %h, got %h", want.name, rsp_result_name);
               error_count++;
            end
            if (rsp_entry_count !== want.count) begin
               $error("rsp_entry_count: expected %0d, got %0d", want.count, rsp_entry_count);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL keyed_record_table");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset            <= 1'b1;
      start            <= 1'b0;
      req_type         <= OP_INSERT;
      req_student_id   <= '0;
      req_student_name <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_table();
      test_extremes_and_duplicates();
      test_reuse_and_unused_code();
      test_random_mix(100, 45);
      test_fill_to_capacity();
      test_random_mix(60, 15);
      test_random_mix(30, 50);

      start <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS keyed_record_table");
      end else begin
         $display("FAIL keyed_record_table");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/krt_pkg.sv
src/krt_ram.sv
src/keyed_record_table.sv
verif/tb.sv
